// ----- design/atxpos_pkg.sv -----
// ----------------------------------------------------------------------------
// atxpos_pkg
// Shared types and constants for the ATX power-on sequencer.
// ----------------------------------------------------------------------------
package atxpos_pkg;

  // Elapsed-time counter width
  localparam int TIMER_WIDTH_DEF = 16;

  localparam int LIMIT_WIDTH = 16;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GOOD_TIMEOUT = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFF_CONFIRM  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETTLE       = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RETRY_OFF    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RETRY_ENABLE = 3'd4;

  // Register reset values
  localparam logic [LIMIT_WIDTH-1:0] GOOD_TIMEOUT_DEF = 16'd1000;
  localparam logic [LIMIT_WIDTH-1:0] OFF_CONFIRM_DEF  = 16'd2000;
  localparam logic [LIMIT_WIDTH-1:0] SETTLE_DEF       = 16'd100;
  localparam logic [LIMIT_WIDTH-1:0] RETRY_PAUSE_MS   = 16'd200;
  localparam logic                   RETRY_ENABLE_DEF = 1'b1;

  // Command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  typedef enum logic [2:0] {
    PH_OFF    = 3'd0,
    PH_CLEAR  = 3'd1,
    PH_WAIT   = 3'd2,
    PH_PAUSE  = 3'd3,
    PH_SETTLE = 3'd4,
    PH_ON     = 3'd5,
    PH_FAIL   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       pwr_ok;
  } req_t;

  typedef struct packed {
    logic       ps_on_drive;
    logic [2:0] phase;
    logic       done_res;
    logic       success;
  } rsp_t;

  typedef struct packed {
    logic [LIMIT_WIDTH-1:0] good_timeout_ms;
    logic [LIMIT_WIDTH-1:0] off_confirm_ms;
    logic [LIMIT_WIDTH-1:0] settle_ms;
    logic [LIMIT_WIDTH-1:0] retry_off_ms;
    logic                   retry_enable;
  } cfg_t;

endpackage

// ----- design/atxpos_cfg.sv -----
// ----------------------------------------------------------------------------
// atxpos_cfg
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module atxpos_cfg import atxpos_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.good_timeout_ms <= GOOD_TIMEOUT_DEF;
      cfg.off_confirm_ms  <= OFF_CONFIRM_DEF;
      cfg.settle_ms       <= SETTLE_DEF;
      cfg.retry_off_ms    <= RETRY_PAUSE_MS;
      cfg.retry_enable    <= RETRY_ENABLE_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GOOD_TIMEOUT: cfg.good_timeout_ms <= cfg_data[LIMIT_WIDTH-1:0];
        REG_OFF_CONFIRM:  cfg.off_confirm_ms  <= cfg_data[LIMIT_WIDTH-1:0];
        REG_SETTLE:       cfg.settle_ms       <= cfg_data[LIMIT_WIDTH-1:0];
        REG_RETRY_OFF:    cfg.retry_off_ms    <= cfg_data[LIMIT_WIDTH-1:0];
        REG_RETRY_ENABLE: cfg.retry_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/atxpos_core.sv -----
// ----------------------------------------------------------------------------
// atxpos_core
// Sequencer state and single-pass next-state/result logic.
// ----------------------------------------------------------------------------
module atxpos_core import atxpos_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  req_t req,
  input  cfg_t cfg,
  output rsp_t result
);

  // compare width covers both the counter and the 16-bit limits
  localparam int CW = (TIMER_WIDTH > LIMIT_WIDTH) ? TIMER_WIDTH : LIMIT_WIDTH;
  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

  phase_t                 phase_reg, phase_next;
  logic [TIMER_WIDTH-1:0] elapsed_ms, elapsed_next;
  logic                   retried, retried_next;
  logic                   ps_on_reg, ps_on_next;
  logic                   done, ok, busy;

  logic [LIMIT_WIDTH-1:0] wait_lim, delay_lim;
  logic [TIMER_WIDTH-1:0] el_inc, el_sat;
  logic                   el_max, wait_exp, delay_end;

  assign busy = (phase_reg == PH_CLEAR) || (phase_reg == PH_WAIT) ||
                (phase_reg == PH_PAUSE) || (phase_reg == PH_SETTLE);

  assign wait_lim  = (phase_reg == PH_CLEAR) ? cfg.off_confirm_ms : cfg.good_timeout_ms;
  assign delay_lim = (phase_reg == PH_PAUSE) ? cfg.retry_off_ms : cfg.settle_ms;

  assign el_max    = (elapsed_ms == TMAX);
  assign el_inc    = elapsed_ms + TIMER_WIDTH'(1);
  assign el_sat    = el_max ? elapsed_ms : el_inc;
  // saturated count expires every limit
  assign wait_exp  = (CW'(elapsed_ms) >= CW'(wait_lim)) || el_max;
  assign delay_end = (CW'(el_sat) >= CW'(delay_lim)) || (el_sat == TMAX);

  always_comb begin
    phase_next   = phase_reg;
    elapsed_next = elapsed_ms;
    retried_next = retried;
    ps_on_next   = ps_on_reg;
    done         = 1'b0;
    ok           = 1'b0;
    unique case (req.cmd)
      CMD_OFF: begin
        done         = busy;
        phase_next   = PH_OFF;
        ps_on_next   = 1'b0;
        elapsed_next = '0;
        retried_next = 1'b0;
      end
      CMD_ON: begin
        if (!busy) begin
          retried_next = 1'b0;
          elapsed_next = '0;
          if (req.pwr_ok) begin
            phase_next = PH_CLEAR;
            ps_on_next = 1'b0;
          end else begin
            phase_next = PH_WAIT;
            ps_on_next = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        unique case (phase_reg)
          PH_CLEAR: begin
            if (!req.pwr_ok || wait_exp) begin
              phase_next   = PH_WAIT;
              ps_on_next   = 1'b1;
              elapsed_next = '0;
            end else begin
              elapsed_next = el_inc;
            end
          end
          PH_WAIT: begin
            if (req.pwr_ok) begin
              phase_next   = PH_SETTLE;
              ps_on_next   = 1'b1;
              elapsed_next = '0;
            end else if (wait_exp) begin
              elapsed_next = '0;
              if (cfg.retry_enable && !retried) begin
                retried_next = 1'b1;
                phase_next   = PH_PAUSE;
                ps_on_next   = 1'b0;
              end else begin
                phase_next = PH_FAIL;
                ps_on_next = 1'b1;
                done       = 1'b1;
              end
            end else begin
              elapsed_next = el_inc;
            end
          end
          PH_PAUSE: begin
            if (delay_end) begin
              phase_next   = PH_WAIT;
              ps_on_next   = 1'b1;
              elapsed_next = '0;
            end else begin
              elapsed_next = el_sat;
            end
          end
          PH_SETTLE: begin
            // power good is not watched while settling
            if (delay_end) begin
              phase_next   = PH_ON;
              ps_on_next   = 1'b1;
              elapsed_next = '0;
              done         = 1'b1;
              ok           = 1'b1;
            end else begin
              elapsed_next = el_sat;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg  <= PH_OFF;
      elapsed_ms <= '0;
      retried    <= 1'b0;
      ps_on_reg  <= 1'b0;
    end else if (take) begin
      phase_reg  <= phase_next;
      elapsed_ms <= elapsed_next;
      retried    <= retried_next;
      ps_on_reg  <= ps_on_next;
    end
  end

  assign result.ps_on_drive = ps_on_next;
  assign result.phase       = phase_next;
  assign result.done_res    = done;
  assign result.success     = ok;

`ifndef SYNTHESIS
  a_ok_lands_on: assert property (@(posedge clk) disable iff (rst)
    take && result.success |=> phase_reg == PH_ON)
    else $error("success reported without reaching on phase");

  a_drive_matches_phase: assert property (@(posedge clk) disable iff (rst)
    ps_on_reg == ((phase_reg == PH_WAIT) || (phase_reg == PH_SETTLE) ||
                  (phase_reg == PH_ON) || (phase_reg == PH_FAIL)))
    else $error("PS_ON drive inconsistent with phase");

  a_pause_after_retry: assert property (@(posedge clk) disable iff (rst)
    phase_reg == PH_PAUSE |-> retried)
    else $error("retry pause without retry mark");
`endif

endmodule

// ----- design/atx_power_on_sequencer_top.sv -----
// Accepted results are registered in the output register, or in the skid while it is stalled.
// One item per cycle while req_stall is low; the state update is a single combinational pass.
// A two-entry output buffer (output register plus skid) keeps input accepting one more item
// past an output stall; stall rises only when the skid entry holds an item.
// Reset (rst, synchronous): phase off, PS_ON released, counters clear, registers to defaults.
// ----------------------------------------------------------------------------
// atx_power_on_sequencer_top
// ATX power-on sequencer: config registers, sequencer core, output buffer.
// ----------------------------------------------------------------------------
module atx_power_on_sequencer_top import atxpos_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  req_t                       req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output rsp_t                       rsp
);

  cfg_t cfg;
  rsp_t result;
  rsp_t out_data, skid_data;
  logic out_v, skid_v;
  logic take, pop;

  assign req_stall = skid_v;
  assign take      = req_valid && !skid_v;
  assign pop       = out_v && !rsp_stall;
  assign rsp_valid = out_v;
  assign rsp       = out_data;

  atxpos_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  atxpos_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .req    (req),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (take) begin
        if (!out_v || pop) begin
          out_v <= 1'b1;
        end else begin
          skid_v <= 1'b1;
        end
      end else if (pop) begin
        if (skid_v) begin
          skid_v <= 1'b0;
        end else begin
          out_v <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (!out_v || pop) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end else if (pop && skid_v) begin
      out_data <= skid_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid entry held with empty output register");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !skid_v ##1 skid_v |-> $past(rsp_stall) && $past(take))
    else $error("skid filled without a stalled output");

  a_out_fills_on_take: assert property (@(posedge clk) disable iff (rst)
    take |=> out_v)
    else $error("accepted item did not reach output buffer");
`endif

endmodule

// ----- tb/tb_atx_power_on_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_atx_power_on_sequencer_top
// Drives tick / on / off items with sampled power-good into the sequencer and
// checks every status item against a cycle-free model of the on sequence:
// clearing, wait for good, retry pause, settling, abort and failure paths.
// ----------------------------------------------------------------------------
module tb_atx_power_on_sequencer_top;
  import atxpos_pkg::*;

  localparam int TW = TIMER_WIDTH_DEF;
  localparam logic [TW-1:0] COUNT_MAX = '1;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_MAX = '1;
  localparam int HOLD_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_PCT = 27;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;
  logic                       req_valid;
  logic                       req_stall;
  req_t                       req;
  logic                       rsp_valid;
  logic                       rsp_stall;
  rsp_t                       rsp;

  atx_power_on_sequencer_top #(.TIMER_WIDTH(TW)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Sequencer model: limits and state
  logic [LIMIT_WIDTH-1:0] lim_good;
  logic [LIMIT_WIDTH-1:0] lim_clear;
  logic [LIMIT_WIDTH-1:0] lim_settle;
  logic [LIMIT_WIDTH-1:0] lim_pause;
  logic                   retry_allowed;
  phase_t                 seq_phase;
  logic [TW-1:0]          seq_ms;
  logic                   seq_retried;
  logic                   seq_drive;

  rsp_t pending_status[$];

  bit no_idle;
  bit hold_req;
  int fail_count;
  int items_sent;
  int status_checked;
  int ups_seen;
  int downs_seen;

  initial begin : clock_gen
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void enter_phase(phase_t p, logic drive);
    seq_phase = p;
    seq_drive = drive;
    seq_ms = '0;
  endfunction

  // Wait for a level: expires once the count has reached the limit.
  function automatic bit wait_timed_out(logic [LIMIT_WIDTH-1:0] lim);
    if (seq_ms >= lim || seq_ms == COUNT_MAX) return 1'b1;
    seq_ms++;
    return 1'b0;
  endfunction

  // Fixed delay: ends on the tick where the count reaches the limit.
  function automatic bit delay_over(logic [LIMIT_WIDTH-1:0] lim);
    if (seq_ms != COUNT_MAX) seq_ms++;
    return (seq_ms >= lim || seq_ms == COUNT_MAX);
  endfunction

  function automatic void reset_sequencer();
    lim_good = GOOD_TIMEOUT_DEF;
    lim_clear = OFF_CONFIRM_DEF;
    lim_settle = SETTLE_DEF;
    lim_pause = RETRY_PAUSE_MS;
    retry_allowed = RETRY_ENABLE_DEF;
    enter_phase(PH_OFF, 1'b0);
    seq_retried = 1'b0;
  endfunction

  function automatic void store_limit(logic [CFG_INDEX_WIDTH-1:0] idx,
                                      logic [CFG_DATA_WIDTH-1:0] val);
    case (idx)
      REG_GOOD_TIMEOUT: lim_good = val;
      REG_OFF_CONFIRM:  lim_clear = val;
      REG_SETTLE:       lim_settle = val;
      REG_RETRY_OFF:    lim_pause = val;
      REG_RETRY_ENABLE: retry_allowed = val[0];
      default: ;
    endcase
  endfunction

  function automatic rsp_t advance_sequencer(req_t r);
    rsp_t s;
    bit busy;
    s = '0;
    busy = (seq_phase inside {PH_CLEAR, PH_WAIT, PH_PAUSE, PH_SETTLE});
    case (r.cmd)
      CMD_OFF: begin
        if (busy) s.done_res = 1'b1;
        enter_phase(PH_OFF, 1'b0);
        seq_retried = 1'b0;
      end
      CMD_ON: begin
        if (!busy) begin
          seq_retried = 1'b0;
          if (r.pwr_ok) enter_phase(PH_CLEAR, 1'b0);
          else enter_phase(PH_WAIT, 1'b1);
        end
      end
      CMD_TICK: begin
        case (seq_phase)
          PH_CLEAR: begin
            // clearing gives up and asserts PS_ON anyway on expiry
            if (!r.pwr_ok) enter_phase(PH_WAIT, 1'b1);
            else if (wait_timed_out(lim_clear)) enter_phase(PH_WAIT, 1'b1);
          end
          PH_WAIT: begin
            if (r.pwr_ok) begin
              enter_phase(PH_SETTLE, 1'b1);
            end else if (wait_timed_out(lim_good)) begin
              if (retry_allowed && !seq_retried) begin
                seq_retried = 1'b1;
                enter_phase(PH_PAUSE, 1'b0);
              end else begin
                enter_phase(PH_FAIL, 1'b1);
                s.done_res = 1'b1;
              end
            end
          end
          PH_PAUSE: begin
            if (delay_over(lim_pause)) enter_phase(PH_WAIT, 1'b1);
          end
          PH_SETTLE: begin
            if (delay_over(lim_settle)) begin
              enter_phase(PH_ON, 1'b1);
              s.done_res = 1'b1;
              s.success = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    s.ps_on_drive = seq_drive;
    s.phase = seq_phase;
    return s;
  endfunction

  function automatic logic [LIMIT_WIDTH-1:0] pick_limit(bit wide);
    int roll;
    roll = $urandom_range(0, 99);
    if (wide) return LIMIT_WIDTH'($urandom_range(5, 60));
    if (roll < 70) return LIMIT_WIDTH'($urandom_range(0, 4));
    if (roll < 95) return LIMIT_WIDTH'($urandom_range(5, 20));
    return LIMIT_WIDTH'($urandom_range(21, 60));
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Called at a rising edge; returns at the edge that accepted the item, or after a random idle gap.
  task automatic send_item(logic [1:0] c, logic pg);
    req_t r;
    r.cmd = c;
    r.pwr_ok = pg;
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_status.push_back(advance_sequencer(r));
    items_sent++;
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Mostly ticks; power good leans away from what the current phase waits on.
  task automatic send_random_item();
    int roll;
    int pg_pct;
    logic [1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 78) c = CMD_TICK;
    else if (roll < 88) c = CMD_ON;
    else if (roll < 97) c = CMD_OFF;
    else c = CMD_SPARE;
    case (seq_phase)
      PH_CLEAR: pg_pct = 75;
      PH_WAIT:  pg_pct = 30;
      default:  pg_pct = 50;
    endcase
    send_item(c, $urandom_range(0, 99) < pg_pct);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    store_limit(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_limits(logic [LIMIT_WIDTH-1:0] good, logic [LIMIT_WIDTH-1:0] clear,
                              logic [LIMIT_WIDTH-1:0] settle, logic [LIMIT_WIDTH-1:0] pause,
                              logic [CFG_DATA_WIDTH-1:0] retry);
    wait_idle();
    write_reg(REG_GOOD_TIMEOUT, good);
    write_reg(REG_OFF_CONFIRM, clear);
    write_reg(REG_SETTLE, settle);
    write_reg(REG_RETRY_OFF, pause);
    write_reg(REG_RETRY_ENABLE, retry);
  endtask

  // Reset limits: clear, early power-good drop, ignored on, abort, spare code.
  task automatic test_reset_limits();
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_ON, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_ON, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_OFF, 1'b0);
    send_item(CMD_SPARE, 1'b1);
  endtask

  // Expiry on limit+1, retry pause, failure, clearing expiry, settle ignoring pg.
  task automatic test_timeouts_and_retry();
    apply_limits(16'd1, 16'd1, 16'd0, 16'd1, 16'd1);
    send_item(CMD_ON, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_ON, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_OFF, 1'b1);
    apply_limits(16'd0, 16'd1, 16'd0, 16'd1, 16'd0);
    send_item(CMD_ON, 1'b0);
    send_item(CMD_TICK, 1'b0);
  endtask

  task automatic test_register_extremes();
    apply_limits(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 16'hFFFF);
    send_item(CMD_ON, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_OFF, 1'b0);
    apply_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFE);
    // unmapped index must leave every limit alone
    write_reg(REG_UNMAPPED, CFG_DATA_WIDTH'($urandom));
    write_reg(REG_RETRY_ENABLE, 16'd1);
    send_item(CMD_ON, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b0);
  endtask

  // Output held off long enough for the buffer to fill and stall the input.
  task automatic test_backpressure();
    apply_limits(pick_limit(0), pick_limit(0), pick_limit(0), pick_limit(0), 16'd1);
    hold_req = 1'b1;
    repeat (40) send_random_item();
  endtask

  task automatic test_random_sequences();
    for (int ph = 0; ph < 6; ph++) begin
      apply_limits(pick_limit(ph == 4), pick_limit(ph == 4), pick_limit(ph == 4),
                   pick_limit(ph == 4), CFG_DATA_WIDTH'($urandom_range(0, 1)));
      no_idle = (ph == 2);
      repeat (265) send_random_item();
      no_idle = 1'b0;
    end
  endtask

  initial begin : rsp_driver
    int hold_left;
    bit hold_started;
    hold_left = 0;
    hold_started = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : status_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_status.size() == 0) begin
        note_failure($sformatf("unexpected status item: drive %0b phase %0d done %0b ok %0b",
                               rsp.ps_on_drive, rsp.phase, rsp.done_res, rsp.success));
      end else begin
        want = pending_status.pop_front();
        status_checked++;
        if (want.done_res) begin
          if (want.success) ups_seen++;
          else downs_seen++;
        end
        if (rsp.ps_on_drive !== want.ps_on_drive || rsp.phase !== want.phase ||
            rsp.done_res !== want.done_res || rsp.success !== want.success) begin
          note_failure($sformatf(
              "status %0d: drive %0b/%0b phase %0d/%0d done %0b/%0b ok %0b/%0b (got/exp)",
              status_checked, rsp.ps_on_drive, want.ps_on_drive, rsp.phase, want.phase,
              rsp.done_res, want.done_res, rsp.success, want.success));
        end
      end
    end
  end

  initial begin : watchdog
    int dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) dead_cycles = 0;
      else dead_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("atx_power_on_sequencer_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    fail_count = 0;
    items_sent = 0;
    status_checked = 0;
    ups_seen = 0;
    downs_seen = 0;
    reset_sequencer();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_limits();
    test_timeouts_and_retry();
    test_register_extremes();
    test_backpressure();
    test_random_sequences();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d items sent, %0d status items checked", items_sent, status_checked);
    $display("sequences ended: %0d came up, %0d failed or aborted", ups_seen, downs_seen);
    if (fail_count == 0) begin
      $display("atx_power_on_sequencer_top: match");
    end else begin
      $display("%0d failures", fail_count);
      $display("atx_power_on_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule
